// ===== sv/wrcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrcw_pkg
// Types, codes and constants shared by the RIFF/WAVE chunk walker.
// ----------------------------------------------------------------------------
package wrcw_pkg;

  localparam logic [31:0] TAG_FMT     = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA    = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN_LEN = 32'h0000_000E;
  localparam logic [32:0] FIRST_CHUNK = 33'd12;
  localparam logic [31:0] FMT_FIELDS  = 32'd12;
  localparam logic [3:0]  TAG_LAST    = 4'd11;
  localparam logic [3:0]  SIZE_FIRST  = 4'd4;
  localparam logic [3:0]  SIZE_LAST   = 4'd7;
  localparam logic [2:0]  HDR_LAST    = 3'd7;
  localparam logic [3:0]  FMT_CH_LO   = 4'd2;
  localparam logic [3:0]  FMT_CH_HI   = 4'd3;
  localparam logic [3:0]  FMT_RATE_LO = 4'd4;
  localparam logic [3:0]  FMT_RATE_HI = 4'd7;
  localparam logic [3:0]  FMT_BR_LO   = 4'd8;
  localparam logic [3:0]  FMT_BR_HI   = 4'd11;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_TAG   = 2'd1,
    ST_FMT_SHORT = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    PH_TAGS      = 5'b00001,
    PH_HEADER    = 5'b00010,
    PH_FMT_BODY  = 5'b00100,
    PH_EXHAUSTED = 5'b01000,
    PH_FINISHED  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } byte_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] channel_count;
    logic [31:0] sample_freq;
    logic [31:0] byte_rate;
    logic [31:0] payload_offset;
    logic [31:0] payload_size;
  } result_t;

  function automatic logic [7:0] riff_tag_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h52;
      4'd1:    val = 8'h49;
      4'd2:    val = 8'h46;
      4'd3:    val = 8'h46;
      4'd8:    val = 8'h57;
      4'd9:    val = 8'h41;
      4'd10:   val = 8'h56;
      4'd11:   val = 8'h45;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== sv/wrcw_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrcw_in_if
// Byte stream channel: one file byte and its end-of-file mark per transaction.
// ----------------------------------------------------------------------------
interface wrcw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source(output valid, output file_byte, output end_of_file, input ready);
  modport sink(input valid, input file_byte, input end_of_file, output ready);
endinterface

// ===== sv/wrcw_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrcw_out_if
// Result channel: parse status and header fields, one result per transaction.
// ----------------------------------------------------------------------------
interface wrcw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] channel_count;
  logic [31:0] sample_freq;
  logic [31:0] byte_rate;
  logic [31:0] payload_offset;
  logic [31:0] payload_size;

  modport source(output valid, output status, output channel_count, output sample_freq,
                 output byte_rate, output payload_offset, output payload_size,
                 input ready);
  modport sink(input valid, input status, input channel_count, input sample_freq,
               input byte_rate, input payload_offset, input payload_size,
               output ready);
endinterface

// ===== sv/wrcw_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrcw_core
// Per-byte header walk: tag check, chunk header capture, fmt field capture.
// ----------------------------------------------------------------------------
module wrcw_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  wrcw_pkg::byte_t  item,
  output logic             res_valid,
  output wrcw_pkg::result_t res
);
  import wrcw_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  tag_cnt, tag_cnt_next;
  logic [31:0] walk_size, walk_size_next;
  logic [32:0] walk_end, walk_end_next;
  logic [32:0] chunk_base, chunk_base_next;
  logic        walk_done, walk_done_next;
  logic [63:0] header_shift, header_shift_next;
  logic [2:0]  hdr_idx, hdr_idx_next;
  logic [31:0] skip, skip_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [3:0]  fmt_cnt, fmt_cnt_next;
  logic        fmt_seen, fmt_seen_next;
  logic        payload_seen, payload_seen_next;
  logic [15:0] saved_channels, saved_channels_next;
  logic [31:0] saved_rate, saved_rate_next;
  logic [31:0] saved_byte_rate, saved_byte_rate_next;
  logic [31:0] saved_offset, saved_offset_next;
  logic [31:0] saved_size, saved_size_next;

  logic [7:0]  b;
  logic [63:0] hdr_new;
  logic [31:0] len_sel;
  logic [33:0] next_base;
  logic        clamp;
  logic [32:0] adv_base;
  logic [31:0] adv_skip;
  logic        fire;
  status_t     fire_status;

  assign b       = item.file_byte;
  assign hdr_new = {b, header_shift[63:8]};
  assign len_sel = (phase == PH_FMT_BODY) ? chunk_length : hdr_new[63:32];
  assign next_base = {1'b0, chunk_base} + 34'd8 + {2'b00, len_sel};
  assign clamp    = next_base >= {1'b0, walk_end};
  assign adv_base = clamp ? walk_end : next_base[32:0];
  assign adv_skip = (phase == PH_FMT_BODY) ? (len_sel - FMT_FIELDS) : len_sel;

  always_comb begin
    phase_next           = phase;
    tag_cnt_next         = tag_cnt;
    walk_size_next       = walk_size;
    walk_end_next        = walk_end;
    chunk_base_next      = chunk_base;
    walk_done_next       = walk_done;
    header_shift_next    = header_shift;
    hdr_idx_next         = hdr_idx;
    skip_next            = skip;
    chunk_length_next    = chunk_length;
    fmt_cnt_next         = fmt_cnt;
    fmt_seen_next        = fmt_seen;
    payload_seen_next    = payload_seen;
    saved_channels_next  = saved_channels;
    saved_rate_next      = saved_rate;
    saved_byte_rate_next = saved_byte_rate;
    saved_offset_next    = saved_offset;
    saved_size_next      = saved_size;
    fire                 = 1'b0;
    fire_status          = ST_OK;

    case (phase)
      PH_TAGS: begin
        tag_cnt_next = tag_cnt + 4'd1;
        if (tag_cnt >= SIZE_FIRST && tag_cnt <= SIZE_LAST) begin
          walk_size_next = {b, walk_size[31:8]};
        end else if (b != riff_tag_byte(tag_cnt)) begin
          fire        = 1'b1;
          fire_status = ST_BAD_TAG;
          phase_next  = PH_FINISHED;
        end
        if (!fire && tag_cnt == TAG_LAST) begin
          walk_end_next   = {1'b0, walk_size} + 33'd8;
          chunk_base_next = FIRST_CHUNK;
          walk_done_next  = walk_end_next <= FIRST_CHUNK;
          hdr_idx_next    = '0;
          skip_next       = '0;
          phase_next      = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (walk_done) begin
          phase_next = PH_EXHAUSTED;
        end else if (skip != '0) begin
          skip_next = skip - 32'd1;
        end else begin
          header_shift_next = hdr_new;
          hdr_idx_next      = hdr_idx + 3'd1;
          if (hdr_idx == HDR_LAST) begin
            chunk_length_next = hdr_new[63:32];
            if (hdr_new[31:0] == TAG_FMT && !fmt_seen) begin
              if (hdr_new[63:32] < FMT_MIN_LEN) begin
                fire        = 1'b1;
                fire_status = ST_FMT_SHORT;
                phase_next  = PH_FINISHED;
              end else begin
                fmt_seen_next = 1'b1;
                fmt_cnt_next  = '0;
                phase_next    = PH_FMT_BODY;
              end
            end else if (hdr_new[31:0] == TAG_DATA && !payload_seen) begin
              saved_offset_next = chunk_base[31:0] + 32'd8;
              saved_size_next   = hdr_new[63:32];
              payload_seen_next = hdr_new[63:32] != '0;
              if (fmt_seen) begin
                fire        = 1'b1;
                fire_status = ST_OK;
                phase_next  = PH_FINISHED;
              end else begin
                chunk_base_next = adv_base;
                walk_done_next  = clamp;
                skip_next       = adv_skip;
              end
            end else begin
              chunk_base_next = adv_base;
              walk_done_next  = clamp;
              skip_next       = adv_skip;
            end
          end
        end
      end
      PH_FMT_BODY: begin
        fmt_cnt_next = fmt_cnt + 4'd1;
        if (fmt_cnt == FMT_CH_LO || fmt_cnt == FMT_CH_HI) begin
          saved_channels_next = {b, saved_channels[15:8]};
        end else if (fmt_cnt >= FMT_RATE_LO && fmt_cnt <= FMT_RATE_HI) begin
          saved_rate_next = {b, saved_rate[31:8]};
        end else if (fmt_cnt >= FMT_BR_LO && fmt_cnt <= FMT_BR_HI) begin
          saved_byte_rate_next = {b, saved_byte_rate[31:8]};
        end
        if (fmt_cnt == FMT_BR_HI) begin
          if (payload_seen) begin
            fire        = 1'b1;
            fire_status = ST_OK;
            phase_next  = PH_FINISHED;
          end else begin
            chunk_base_next = adv_base;
            walk_done_next  = clamp;
            skip_next       = adv_skip;
            hdr_idx_next    = '0;
            phase_next      = PH_HEADER;
          end
        end
      end
      default: begin
      end
    endcase

    if (item.end_of_file) begin
      if (!fire && phase_next != PH_FINISHED) begin
        fire        = 1'b1;
        fire_status = (phase_next == PH_TAGS) ? ST_BAD_TAG : ST_NOT_FOUND;
      end
      phase_next        = PH_TAGS;
      tag_cnt_next      = '0;
      walk_done_next    = 1'b0;
      hdr_idx_next      = '0;
      skip_next         = '0;
      fmt_cnt_next      = '0;
      fmt_seen_next     = 1'b0;
      payload_seen_next = 1'b0;
    end
  end

  assign res_valid = step && fire;

  always_comb begin
    res        = '0;
    res.status = fire_status;
    if (fire_status == ST_OK) begin
      res.channel_count  = saved_channels_next;
      res.sample_freq    = saved_rate_next;
      res.byte_rate      = saved_byte_rate_next;
      res.payload_offset = saved_offset_next;
      res.payload_size   = saved_size_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TAGS;
      tag_cnt      <= '0;
      walk_done    <= 1'b0;
      hdr_idx      <= '0;
      skip         <= '0;
      fmt_cnt      <= '0;
      fmt_seen     <= 1'b0;
      payload_seen <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      tag_cnt      <= tag_cnt_next;
      walk_done    <= walk_done_next;
      hdr_idx      <= hdr_idx_next;
      skip         <= skip_next;
      fmt_cnt      <= fmt_cnt_next;
      fmt_seen     <= fmt_seen_next;
      payload_seen <= payload_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      walk_size       <= walk_size_next;
      walk_end        <= walk_end_next;
      chunk_base      <= chunk_base_next;
      header_shift    <= header_shift_next;
      chunk_length    <= chunk_length_next;
      saved_channels  <= saved_channels_next;
      saved_rate      <= saved_rate_next;
      saved_byte_rate <= saved_byte_rate_next;
      saved_offset    <= saved_offset_next;
      saved_size      <= saved_size_next;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (step && item.end_of_file) |=> (phase == PH_TAGS && tag_cnt == '0 && !fmt_seen))
    else $error("walk not restarted after last byte");

  a_result_finishes: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !item.end_of_file) |=> (phase == PH_FINISHED))
    else $error("result without finishing the walk");

  a_ok_needs_fmt: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_OK) |-> fmt_seen)
    else $error("ok status before fmt chunk");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ST_OK) |->
      (res.channel_count == '0 && res.sample_freq == '0 && res.payload_size == '0))
    else $error("failure result carries fields");

endmodule

// ===== sv/wrcw_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrcw_out_reg
// Result holding register driving the result channel.
// ----------------------------------------------------------------------------
module wrcw_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  wrcw_pkg::result_t res,
  output logic              free,
  wrcw_out_if.source        result
);
  import wrcw_pkg::*;

  logic    valid;
  result_t held;

  assign free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign result.valid          = valid;
  assign result.status         = held.status;
  assign result.channel_count  = held.channel_count;
  assign result.sample_freq    = held.sample_freq;
  assign result.byte_rate      = held.byte_rate;
  assign result.payload_offset = held.payload_offset;
  assign result.payload_size   = held.payload_size;

endmodule

// ===== sv/wav_riff_chunk_walker.sv =====
// ----------------------------------------------------------------------------
// wav_riff_chunk_walker
// Result path: the byte is buffered, steps the walk, and its result is registered.
// Throughput: one byte per cycle while the output register is free, set by the walk update.
// A result waiting at the output holds the walk; one more byte is buffered.
// Reset: synchronous, clears the walk state; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module wav_riff_chunk_walker (
  input  logic      clk,
  input  logic      rst,
  wrcw_in_if.sink   bytes,
  wrcw_out_if.source result
);
  import wrcw_pkg::*;

  logic    in_valid;
  byte_t   in_item;
  logic    step;
  logic    out_free;
  logic    res_valid;
  result_t res;

  assign step        = in_valid && out_free;
  assign bytes.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_item <= '{file_byte: bytes.file_byte, end_of_file: bytes.end_of_file};
    end
  end

  wrcw_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  wrcw_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (res_valid),
    .res    (res),
    .free   (out_free),
    .result (result)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RIFF/WAVE chunk walker. It first streams a table
// of hand-built files (tag faults, short and cut fmt chunks, empty data chunks,
// walk-end clamping), then randomly shaped files, one byte per transaction.
// A byte-level walk predictor gives the expected results (typed rows: table status).
// ----------------------------------------------------------------------------
module tb;
  import wrcw_pkg::*;

  localparam logic [31:0] RIFF_ID  = 32'h4646_4952;
  localparam logic [31:0] WAVE_ID  = 32'h4556_4157;
  localparam logic [31:0] FMT_ID   = 32'h2074_6D66;
  localparam logic [31:0] DATA_ID  = 32'h6174_6164;
  localparam logic [31:0] LIST_ID  = 32'h5453_494C;
  localparam logic [31:0] FMT_MIN  = 32'd14;
  localparam logic [95:0] HDR_TAGS = {WAVE_ID, 32'h0, RIFF_ID};
  localparam int RAND_BYTES = 700;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum logic [3:0] {
    SH_SHORT_FILE, SH_BAD_RIFF, SH_BAD_WAVE, SH_FMT_SHORT,
    SH_NO_CHUNKS, SH_FMT_CUT, SH_EXTREME, SH_ZERO_FIELDS,
    SH_DATA_FIRST, SH_EMPTY_DATA_LAST, SH_EMPTY_DATA_FIRST, SH_EMPTY_DATA_ONLY,
    SH_FMT_TWICE, SH_HDR_PAST_END, SH_JUMP_PAST_END, SH_ODD_JUNK
  } shape_t;

  typedef struct packed {
    shape_t  shape;
    logic    typed;
    status_t status;
  } row_t;

  row_t rows [16] = '{
    '{SH_SHORT_FILE,       1'b1, ST_BAD_TAG},
    '{SH_BAD_RIFF,         1'b1, ST_BAD_TAG},
    '{SH_BAD_WAVE,         1'b1, ST_BAD_TAG},
    '{SH_FMT_SHORT,        1'b1, ST_FMT_SHORT},
    '{SH_NO_CHUNKS,        1'b1, ST_NOT_FOUND},
    '{SH_FMT_CUT,          1'b1, ST_NOT_FOUND},
    '{SH_JUMP_PAST_END,    1'b1, ST_NOT_FOUND},
    '{SH_EXTREME,          1'b0, ST_OK},
    '{SH_ZERO_FIELDS,      1'b0, ST_OK},
    '{SH_DATA_FIRST,       1'b0, ST_OK},
    '{SH_EMPTY_DATA_LAST,  1'b0, ST_OK},
    '{SH_EMPTY_DATA_FIRST, 1'b0, ST_OK},
    '{SH_EMPTY_DATA_ONLY,  1'b0, ST_OK},
    '{SH_FMT_TWICE,        1'b0, ST_OK},
    '{SH_HDR_PAST_END,     1'b0, ST_OK},
    '{SH_ODD_JUNK,         1'b0, ST_OK}
  };

  logic clk;
  logic rst;

  wrcw_in_if  bytes_if ();
  wrcw_out_if res_if ();

  wav_riff_chunk_walker dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_if),
    .result (res_if)
  );

  // walk predictor state
  logic [32:0] w_pos;
  logic [32:0] w_end;
  logic [32:0] w_base;
  logic [63:0] w_hdr;
  logic [31:0] w_len;
  logic        w_fmt;
  logic        w_data;
  logic [15:0] w_ch;
  logic [31:0] w_rate;
  logic [31:0] w_brate;
  logic [31:0] w_off;
  logic [31:0] w_size;
  phase_t      w_phase;

  result_t    header_q [$];
  logic [7:0] file_q [$];

  int gap_pct;
  int stall_pct;
  int byte_cnt;
  int file_cnt;
  int result_cnt;
  int fail_cnt;
  int status_seen [4];
  int cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic result_t fail_result(status_t s);
    result_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  function automatic result_t ok_result();
    result_t r;
    r.status         = ST_OK;
    r.channel_count  = w_ch;
    r.sample_freq    = w_rate;
    r.byte_rate      = w_brate;
    r.payload_offset = w_off;
    r.payload_size   = w_size;
    return r;
  endfunction

  task automatic walker_clear();
    w_pos   = '0;
    w_end   = '0;
    w_base  = 33'd12;
    w_hdr   = '0;
    w_len   = '0;
    w_fmt   = 1'b0;
    w_data  = 1'b0;
    w_ch    = '0;
    w_rate  = '0;
    w_brate = '0;
    w_off   = '0;
    w_size  = '0;
    w_phase = PH_TAGS;
  endtask

  task automatic next_chunk();
    logic [33:0] nxt;
    nxt = {1'b0, w_base} + 34'd8 + 34'(w_len);
    w_base  = (nxt >= {1'b0, w_end}) ? w_end : nxt[32:0];
    w_hdr   = '0;
    w_phase = PH_HEADER;
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic eof,
                           output bit got, output result_t res);
    logic [32:0] p;
    logic [32:0] r;
    logic [2:0]  i;
    logic [31:0] tag;
    p   = w_pos;
    got = 1'b0;
    res = '0;
    case (w_phase)
      PH_TAGS: begin
        if (p < 33'd12) begin
          if (p >= 33'd4 && p < 33'd8) begin
            w_end = w_end | (33'(b) << (8 * (p - 33'd4)));
          end else if (b != HDR_TAGS[8 * p[3:0] +: 8]) begin
            got = 1'b1;
            res = fail_result(ST_BAD_TAG);
            w_phase = PH_FINISHED;
          end
          if (!got && p == 33'd11) begin
            w_end = w_end + 33'd8;
            w_phase = PH_HEADER;
          end
        end
      end
      PH_HEADER: begin
        if (w_base >= w_end) begin
          w_phase = PH_EXHAUSTED;
        end else if (p >= w_base && p - w_base < 33'd8) begin
          i = 3'(p - w_base);
          w_hdr = w_hdr | (64'(b) << (8 * i));
          if (i == 3'd7) begin
            tag   = w_hdr[31:0];
            w_len = w_hdr[63:32];
            if (tag == FMT_ID && !w_fmt) begin
              if (w_len < FMT_MIN) begin
                got = 1'b1;
                res = fail_result(ST_FMT_SHORT);
                w_phase = PH_FINISHED;
              end else begin
                w_fmt = 1'b1;
                w_phase = PH_FMT_BODY;
              end
            end else if (tag == DATA_ID && !w_data) begin
              w_off  = w_base[31:0] + 32'd8;
              w_size = w_len;
              w_data = (w_len != '0);
              if (w_fmt) begin
                got = 1'b1;
                res = ok_result();
                w_phase = PH_FINISHED;
              end else begin
                next_chunk();
              end
            end else begin
              next_chunk();
            end
          end
        end
      end
      PH_FMT_BODY: begin
        if (p >= w_base + 33'd8) begin
          r = p - w_base - 33'd8;
          if (r == 33'd2 || r == 33'd3)
            w_ch = w_ch | (16'(b) << (8 * (r - 33'd2)));
          else if (r >= 33'd4 && r < 33'd8)
            w_rate = w_rate | (32'(b) << (8 * (r - 33'd4)));
          else if (r >= 33'd8 && r < 33'd12)
            w_brate = w_brate | (32'(b) << (8 * (r - 33'd8)));
          if (r == 33'd11) begin
            if (w_data) begin
              got = 1'b1;
              res = ok_result();
              w_phase = PH_FINISHED;
            end else begin
              next_chunk();
            end
          end
        end
      end
      default: ;
    endcase
    if (w_pos != {33{1'b1}}) w_pos = w_pos + 33'd1;
    if (eof) begin
      if (!got && w_phase != PH_FINISHED) begin
        got = 1'b1;
        res = fail_result(w_phase == PH_TAGS ? ST_BAD_TAG : ST_NOT_FOUND);
      end
      walker_clear();
    end
  endtask

  // file building
  function automatic void put8(logic [7:0] v);
    file_q.push_back(v);
  endfunction

  function automatic void put32(logic [31:0] v);
    for (int k = 0; k < 4; k++) file_q.push_back(v[8 * k +: 8]);
  endfunction

  function automatic void put_riff(logic [31:0] size);
    put32(RIFF_ID);
    put32(size);
    put32(WAVE_ID);
  endfunction

  function automatic void set_riff_size(logic [31:0] size);
    for (int k = 0; k < 4; k++) file_q[4 + k] = size[8 * k +: 8];
  endfunction

  function automatic void put_chunk(logic [31:0] tag, logic [31:0] len, int body);
    put32(tag);
    put32(len);
    repeat (body) put8(8'($urandom));
  endfunction

  function automatic void put_fmt(logic [31:0] len, int body, logic [15:0] ch,
                                  logic [31:0] rate, logic [31:0] br);
    logic [95:0] f;
    f = {br, rate, ch, 16'd1};
    put32(FMT_ID);
    put32(len);
    for (int k = 0; k < body; k++) put8(k < 12 ? f[8 * k +: 8] : 8'($urandom));
  endfunction

  function automatic void fmt_any(logic [31:0] len, int body);
    put_fmt(len, body, 16'($urandom), $urandom, $urandom);
  endfunction

  function automatic void compose_row(shape_t shape);
    bit exact;
    int mark;
    exact = 1'b1;
    mark  = 0;
    file_q.delete();
    case (shape)
      SH_SHORT_FILE: begin
        put32(RIFF_ID);
        put8(8'h00);
        exact = 1'b0;
      end
      SH_BAD_RIFF: begin
        put_riff('0); fmt_any(16, 16); put_chunk(DATA_ID, 4, 4);
        file_q[0] = 8'h72;
      end
      SH_BAD_WAVE: begin
        put_riff('0); fmt_any(16, 16); put_chunk(DATA_ID, 4, 4);
        file_q[11] = 8'h65;
      end
      SH_FMT_SHORT: begin
        put_riff('0); fmt_any(13, 13); put_chunk(DATA_ID, 4, 4);
      end
      SH_NO_CHUNKS: begin
        put_riff(32'd4);
        repeat (6) put8(8'($urandom));
        exact = 1'b0;
      end
      SH_FMT_CUT: begin
        put_riff('0); fmt_any(16, 5);
      end
      SH_EXTREME: begin
        put_riff('1);
        put_fmt(16, 16, '1, '1, '1);
        put_chunk(DATA_ID, '1, 6);
        exact = 1'b0;
      end
      SH_ZERO_FIELDS: begin
        put_riff('0); put_fmt(14, 14, '0, '0, '0); put_chunk(DATA_ID, 1, 1);
      end
      SH_DATA_FIRST: begin
        put_riff('0); put_chunk(DATA_ID, 3, 3); fmt_any(16, 16);
      end
      SH_EMPTY_DATA_LAST: begin
        put_riff('0); fmt_any(16, 16); put_chunk(DATA_ID, 0, 0);
      end
      SH_EMPTY_DATA_FIRST: begin
        put_riff('0); put_chunk(DATA_ID, 0, 0); fmt_any(18, 18); put_chunk(DATA_ID, 5, 5);
      end
      SH_EMPTY_DATA_ONLY: begin
        put_riff('0); put_chunk(DATA_ID, 0, 0); fmt_any(16, 16);
      end
      SH_FMT_TWICE: begin
        put_riff('0); fmt_any(16, 16); put_chunk(FMT_ID, 2, 2); put_chunk(DATA_ID, 4, 4);
      end
      SH_HDR_PAST_END: begin
        put_riff('0); fmt_any(16, 16);
        mark = file_q.size();
        put_chunk(DATA_ID, 9, 9);
        set_riff_size(32'(mark - 4));
        exact = 1'b0;
      end
      SH_JUMP_PAST_END: begin
        put_riff('0); fmt_any(32'hFFFF_FF00, 16); put_chunk(DATA_ID, 4, 4);
      end
      SH_ODD_JUNK: begin
        put_riff('0); put_chunk(LIST_ID, 3, 3); fmt_any(18, 18); put_chunk(DATA_ID, 7, 7);
      end
      default: ;
    endcase
    if (exact) set_riff_size(32'(file_q.size() - 8));
  endfunction

  function automatic void rand_fmt();
    int k;
    int len;
    k = $urandom_range(99);
    if (k < 3) begin
      put_fmt($urandom | 32'h8000_0000, $urandom_range(16), 16'($urandom), $urandom, $urandom);
    end else begin
      if (k < 12) len = $urandom_range(13);
      else if (k < 20) len = $urandom_range(40, 25);
      else len = $urandom_range(24, 14);
      fmt_any(len, len);
    end
  endfunction

  function automatic void rand_data();
    int k;
    int len;
    k = $urandom_range(99);
    if (k < 12) begin
      put_chunk(DATA_ID, 0, 0);
    end else if (k < 20) begin
      put_chunk(DATA_ID, $urandom, $urandom_range(8));
    end else begin
      len = $urandom_range(12, 1);
      put_chunk(DATA_ID, len, len);
    end
  endfunction

  function automatic void rand_junk();
    logic [31:0] tag;
    int len;
    case ($urandom_range(7))
      0: tag = FMT_ID ^ (32'd1 << $urandom_range(31));
      1: tag = DATA_ID ^ (32'd1 << $urandom_range(31));
      2: tag = LIST_ID;
      default: tag = $urandom;
    endcase
    len = $urandom_range(9);
    put_chunk(tag, len, len);
  endfunction

  function automatic void compose_random();
    int k;
    int idx;
    int cut;
    file_q.delete();
    if ($urandom_range(99) < 6) begin
      repeat ($urandom_range(20, 1)) put8(8'($urandom));
      return;
    end
    put_riff('0);
    if ($urandom_range(99) < 72) begin
      if ($urandom_range(3) == 0) rand_junk();
      if ($urandom_range(1) == 1) begin
        rand_fmt();
        if ($urandom_range(3) == 0) rand_junk();
        rand_data();
      end else begin
        rand_data();
        if ($urandom_range(3) == 0) rand_junk();
        rand_fmt();
      end
    end else begin
      repeat ($urandom_range(4)) begin
        case ($urandom_range(2))
          0: rand_fmt();
          1: rand_data();
          default: rand_junk();
        endcase
      end
    end
    repeat ($urandom_range(4)) put8(8'($urandom));
    k = $urandom_range(99);
    if (k < 75) set_riff_size(32'(file_q.size() - 8));
    else if (k < 85) set_riff_size($urandom_range(file_q.size()));
    else if (k < 93) set_riff_size('1);
    else set_riff_size($urandom);
    if ($urandom_range(99) < 5) begin
      idx = $urandom_range(7);
      if (idx >= 4) idx = idx + 4;
      file_q[idx] = file_q[idx] ^ (8'd1 << $urandom_range(7));
    end
    if ($urandom_range(99) < 10) begin
      cut = $urandom_range(file_q.size() - 1, 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endfunction

  task automatic set_idling(int mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 73; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 73; end
      default: begin gap_pct = 19; stall_pct = 19; end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eof,
                           input bit typed, input result_t typed_res);
    bit      got;
    result_t res;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      bytes_if.valid <= 1'b0;
      @(negedge clk);
    end
    bytes_if.valid       <= 1'b1;
    bytes_if.file_byte   <= b;
    bytes_if.end_of_file <= eof;
    do @(posedge clk); while (!bytes_if.ready);
    walk_byte(b, eof, got, res);
    if (got) header_q.push_back(typed ? typed_res : res);
    byte_cnt++;
    @(negedge clk);
  endtask

  task automatic send_file(input bit typed, input result_t typed_res);
    set_idling((file_cnt / 5) % 4);
    for (int k = 0; k < file_q.size(); k++)
      push_byte(file_q[k], k == file_q.size() - 1, typed, typed_res);
    file_cnt++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      fail_cnt++;
    end
  endtask

  // result receiver
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (header_q.size() == 0) begin
        $error("unexpected result transaction, status %0d", res_if.status);
        fail_cnt++;
      end else begin
        want = header_q.pop_front();
        compare_field("status", 32'(want.status), 32'(res_if.status));
        compare_field("channel_count", 32'(want.channel_count), 32'(res_if.channel_count));
        compare_field("sample_freq", want.sample_freq, res_if.sample_freq);
        compare_field("byte_rate", want.byte_rate, res_if.byte_rate);
        compare_field("payload_offset", want.payload_offset, res_if.payload_offset);
        compare_field("payload_size", want.payload_size, res_if.payload_size);
        status_seen[want.status]++;
        result_cnt++;
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, header_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int rand_start;
    rst                  = 1'b1;
    bytes_if.valid       = 1'b0;
    bytes_if.file_byte   = '0;
    bytes_if.end_of_file = 1'b0;
    gap_pct    = 0;
    stall_pct  = 0;
    byte_cnt   = 0;
    file_cnt   = 0;
    result_cnt = 0;
    fail_cnt   = 0;
    foreach (status_seen[k]) status_seen[k] = 0;
    walker_clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[k]) begin
      compose_row(rows[k].shape);
      send_file(rows[k].typed, fail_result(rows[k].status));
    end

    rand_start = byte_cnt;
    while (byte_cnt - rand_start < RAND_BYTES) begin
      compose_random();
      send_file(1'b0, '0);
    end
    bytes_if.valid <= 1'b0;

    while (header_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Streamed %0d bytes in %0d files; %0d results checked, %0d mismatches",
             byte_cnt, file_cnt, result_cnt, fail_cnt);
    $display("Results by status: ok %0d, bad tag %0d, short fmt %0d, not found %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/wrcw_pkg.sv
sv/wrcw_in_if.sv
sv/wrcw_out_if.sv
sv/wrcw_core.sv
sv/wrcw_out_reg.sv
sv/wav_riff_chunk_walker.sv
sim/tb.sv
